// ===== hdl/nearest_snap_point_selector_assert.svh =====
// Assertion macros for the nearest snap point selector.
`ifndef NEAREST_SNAP_POINT_SELECTOR_ASSERT_SVH
`define NEAREST_SNAP_POINT_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define NSPS_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NSPS_ASSERT_RESET(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSPS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define NSPS_ASSERT_RESET(label, clk, prop, msg)
`endif
`endif

// ===== hdl/nsps_pkg.sv =====
// Package with types and constants of the nearest snap point selector.
`timescale 1ns / 1ps
package nsps_pkg;
   localparam int COORD_WIDTH_DEFAULT   = 32;
   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int CsrIdxWidth           = 3;
   localparam int QuotBits              = 32;

   typedef enum logic [2:0] {
      CSR_CURSOR_X    = 3'd0,
      CSR_CURSOR_Y    = 3'd1,
      CSR_TOLERANCE   = 3'd2,
      CSR_REFERENCE_X = 3'd3,
      CSR_REFERENCE_Y = 3'd4,
      CSR_PERP_ENABLE = 3'd5,
      CSR_PRIORITIES  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_ENDPOINT = 3'd0,
      KIND_MIDPOINT = 3'd1,
      KIND_CENTER   = 3'd2,
      KIND_PERP     = 3'd3,
      KIND_SURVEY   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAND,    // squares of candidate offsets
      ST_DECIDE,  // compare against tolerance and best
      ST_PDOT,    // dot product terms
      ST_PLEN,    // length squared terms
      ST_PCHECK,  // clamp tests
      ST_PDIV,    // restoring division, one bit a cycle
      ST_PFOOT_X, // scale x offset
      ST_PFOOT_Y, // scale y offset
      ST_OUT
   } state_type;
endpackage

// ===== hdl/nearest_snap_point_selector.sv =====
// Top level of the nearest snap point selector.
// Channel | Direction | Handshake        | Payload
// req_    | in        | valid / stall    | op, point_kind, a, b, last_item
// rsp_    | out       | valid / stall    | hit_valid, hit_kind, hit_x, hit_y
// csr_    | in        | valid / ready    | index, data
// Each candidate forms two products on the shared multiplier, then a decision. A point item
// offers at most one candidate, a segment its ends and midpoint; a perpendicular foot adds dot,
// length and clamp steps, then a quotient produced one bit a cycle and the foot scaling, unless
// it clamps to an end. Between items the block is idle and squares the tolerance on the same
// multiplier. A query ends in an output state; the result waits in the output register, and
// until it is taken no item is accepted. Synchronous reset clears CSRs, control and kept best.
`timescale 1ns / 1ps
`include "nearest_snap_point_selector_assert.svh"
module nearest_snap_point_selector
   import nsps_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [2:0]                    req_point_kind,
   input  logic signed [31:0]            req_a_x,
   input  logic signed [31:0]            req_a_y,
   input  logic signed [31:0]            req_b_x,
   input  logic signed [31:0]            req_b_y,
   input  logic                          req_last_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit_valid,
   output logic [2:0]                    rsp_hit_kind,
   output logic signed [31:0]            rsp_hit_x,
   output logic signed [31:0]            rsp_hit_y,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [31:0]                   csr_data
);
   // Fixed-point position does not change any compare; it is kept for documentation.
   localparam int FracUnused = FRACTION_BITS;
   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 2;        // width of sums and differences
   localparam int MW = 2 * (CW + 1);  // magnitude product width
   localparam int DW = MW + 2;        // dot / length width with carry room
   localparam int OW = QuotBits + 1;  // shared multiplier operand width

   state_type state_ff, state_in;

   logic signed [CW-1:0] cur_x_ff, cur_y_ff, ref_x_ff, ref_y_ff;
   logic [30:0]          tol_ff;
   logic                 perp_en_ff;
   logic [14:0]          prio_ff;
   logic [63:0]          tol2_ff;

   logic                 op_ff, last_ff;
   logic signed [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   // candidate sequence: 0 a, 1 b, 2 mid, 3 perpendicular
   logic [1:0]           cand_ff, cand_in;
   logic signed [EW-1:0] px_ff, py_ff, px_in, py_in;
   logic [2:0]           ckind_ff, ckind_in;
   logic [63:0]          ex_ff, ey_ff;

   logic                 best_found_ff;
   logic [2:0]           best_kind_ff, best_rank_ff;
   logic signed [CW-1:0] best_x_ff, best_y_ff;
   logic [63:0]          best_d2_ff;

   logic [DW-1:0]        dot_ff, len_ff;
   logic [MW-1:0]        t1_ff, t2_ff;
   logic                 n1_ff, n2_ff;
   logic [QuotBits-1:0]  quot_ff;
   logic [5:0]           cnt_ff;

   logic                 out_valid_ff, out_hit_ff;
   logic [2:0]           out_kind_ff;
   logic signed [31:0]   out_x_ff, out_y_ff;

   // shared multiplier operands
   logic [OW-1:0]        mul_a, mul_b;
   logic [2*OW-1:0]      mul_p;
   logic signed [EW-1:0] sx, sy, vx, vy, rx, ry;
   logic [CW:0]          mvx, mvy, mrx, mry;

   function automatic logic [CW:0] absval(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] n;
      n = -v;
      return v[EW-1] ? n[CW:0] : v[CW:0];
   endfunction

   assign sx  = EW'(ax_ff);
   assign sy  = EW'(ay_ff);
   assign vx  = EW'(bx_ff) - EW'(ax_ff);
   assign vy  = EW'(by_ff) - EW'(ay_ff);
   assign rx  = EW'(ref_x_ff) - EW'(ax_ff);
   assign ry  = EW'(ref_y_ff) - EW'(ay_ff);
   assign mvx = absval(vx);
   assign mvy = absval(vy);
   assign mrx = absval(rx);
   assign mry = absval(ry);

   // current candidate offsets from the cursor
   logic [CW:0] dxm, dym;
   assign dxm = absval(px_ff - EW'(cur_x_ff));
   assign dym = absval(py_ff - EW'(cur_y_ff));

   // per-state multiplier operands; one product per cycle
   logic [1:0] mphase_ff;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a = OW'(tol_ff);
            mul_b = mul_a;
         end
         ST_CAND: begin
            mul_a = (mphase_ff == 2'd0) ? OW'(dxm) : OW'(dym);
            mul_b = mul_a;
         end
         ST_PDOT: begin
            mul_a = (mphase_ff == 2'd0) ? OW'(mrx) : OW'(mry);
            mul_b = (mphase_ff == 2'd0) ? OW'(mvx) : OW'(mvy);
         end
         ST_PLEN: begin
            mul_a = (mphase_ff == 2'd0) ? OW'(mvx) : OW'(mvy);
            mul_b = mul_a;
         end
         ST_PFOOT_X: begin
            mul_a = OW'(mvx);
            mul_b = OW'(quot_ff);
         end
         ST_PFOOT_Y: begin
            mul_a = OW'(mvy);
            mul_b = OW'(quot_ff);
         end
         default: mul_a = '0;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // decision on the current candidate
   logic [64:0] d2_sum;
   logic [63:0] d2;
   logic [2:0]  pri;
   logic        in_tol, better;
   assign d2_sum = {1'b0, ex_ff} + {1'b0, ey_ff};
   assign d2     = d2_sum[64] ? '1 : d2_sum[63:0];
   assign pri    = prio_ff[3*ckind_ff +: 3];
   assign in_tol = d2 <= tol2_ff;
   assign better = !best_found_ff || d2 < best_d2_ff ||
                   (d2 == best_d2_ff && pri > best_rank_ff);

   // division step
   logic [DW:0]   div_sh;
   logic          div_ge;
   assign div_sh = {dot_ff, 1'b0};
   assign div_ge = div_sh >= {1'b0, len_ff};

   logic signed [EW-1:0] mid_x, mid_y;
   assign mid_x = (EW'(ax_ff) + EW'(bx_ff)) >>> 1;
   assign mid_y = (EW'(ay_ff) + EW'(by_ff)) >>> 1;

   // foot offset: the quotient times the offset magnitude, as a fraction of 32 bits
   logic [CW:0] foot_off;
   assign foot_off = mul_p[QuotBits +: CW+1];

   logic last_cand;
   assign last_cand = !op_ff || cand_ff == 2'd3 ||
                      (cand_ff == 2'd2 && !perp_en_ff);

   assign req_stall = (state_ff != ST_IDLE) || out_valid_ff;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_valid && !req_stall) begin
               if (req_op || req_point_kind <= KIND_SURVEY) state_in = ST_CAND;
               else if (req_last_item) state_in = ST_OUT;
            end
         ST_CAND:   if (mphase_ff == 2'd1) state_in = ST_DECIDE;
         ST_DECIDE:
            if (!last_cand) begin
               state_in = (cand_ff == 2'd2) ? ST_PDOT : ST_CAND;
            end else begin
               state_in = last_ff ? ST_OUT : ST_IDLE;
            end
         ST_PDOT:   if (mphase_ff == 2'd1) state_in = ST_PLEN;
         ST_PLEN:   if (mphase_ff == 2'd1) state_in = ST_PCHECK;
         ST_PCHECK: begin
            if (mvx == '0 && mvy == '0) state_in = last_ff ? ST_OUT : ST_IDLE;
            else if ((n1_ff == n2_ff ? n1_ff : (t1_ff >= t2_ff ? n1_ff : n2_ff)) ||
                     dot_ff == '0 || dot_ff >= len_ff) state_in = ST_CAND;
            else state_in = ST_PDIV;
         end
         ST_PDIV:    if (cnt_ff == 6'd31) state_in = ST_PFOOT_X;
         ST_PFOOT_X: state_in = ST_PFOOT_Y;
         ST_PFOOT_Y: state_in = ST_CAND;
         ST_OUT:     state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // candidate selection
   always_comb begin
      cand_in  = cand_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      ckind_in = ckind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cand_in  = '0;
               px_in    = EW'(signed'(req_a_x[CW-1:0]));
               py_in    = EW'(signed'(req_a_y[CW-1:0]));
               ckind_in = req_op ? KIND_ENDPOINT : req_point_kind;
            end
         end
         ST_DECIDE: begin
            cand_in = cand_ff + 2'd1;
            ckind_in = KIND_ENDPOINT;
            if (cand_ff == 2'd0) begin
               px_in = EW'(bx_ff);
               py_in = EW'(by_ff);
            end else begin
               px_in = mid_x;
               py_in = mid_y;
               ckind_in = KIND_MIDPOINT;
            end
         end
         ST_PCHECK: begin
            ckind_in = KIND_PERP;
            if (dot_ff >= len_ff && dot_ff != '0 &&
                !(n1_ff == n2_ff ? n1_ff : (t1_ff >= t2_ff ? n1_ff : n2_ff))) begin
               px_in = EW'(bx_ff);
               py_in = EW'(by_ff);
            end else begin
               px_in = sx;
               py_in = sy;
            end
         end
         ST_PFOOT_X: px_in = vx[EW-1] ? sx - EW'(foot_off) : sx + EW'(foot_off);
         ST_PFOOT_Y: py_in = vy[EW-1] ? sy - EW'(foot_off) : sy + EW'(foot_off);
         default: cand_in = cand_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         ref_x_ff      <= '0;
         ref_y_ff      <= '0;
         tol_ff        <= '0;
         perp_en_ff    <= 1'b0;
         prio_ff       <= '0;
         best_found_ff <= 1'b0;
         best_kind_ff  <= '0;
         best_rank_ff  <= '0;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_d2_ff    <= '0;
         out_valid_ff  <= 1'b0;
         mphase_ff     <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CURSOR_X:    cur_x_ff   <= csr_data[CW-1:0];
               CSR_CURSOR_Y:    cur_y_ff   <= csr_data[CW-1:0];
               CSR_TOLERANCE:   tol_ff     <= csr_data[30:0];
               CSR_REFERENCE_X: ref_x_ff   <= csr_data[CW-1:0];
               CSR_REFERENCE_Y: ref_y_ff   <= csr_data[CW-1:0];
               CSR_PERP_ENABLE: perp_en_ff <= csr_data[0];
               CSR_PRIORITIES:  prio_ff    <= csr_data[14:0];
               default:         prio_ff    <= prio_ff;
            endcase
         end
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (state_ff == ST_CAND || state_ff == ST_PDOT || state_ff == ST_PLEN)
            mphase_ff <= (mphase_ff == 2'd1) ? 2'd0 : 2'd1;
         if (state_ff == ST_PDIV) cnt_ff <= cnt_ff + 6'd1;
         else cnt_ff <= '0;
         if (state_ff == ST_DECIDE && in_tol && better) begin
            best_found_ff <= 1'b1;
            best_kind_ff  <= ckind_ff;
            best_rank_ff  <= pri;
            best_x_ff     <= px_ff[CW-1:0];
            best_y_ff     <= py_ff[CW-1:0];
            best_d2_ff    <= d2;
         end
         if (state_ff == ST_OUT) begin
            out_valid_ff  <= 1'b1;
            best_found_ff <= 1'b0;
            best_kind_ff  <= '0;
            best_rank_ff  <= '0;
            best_x_ff     <= '0;
            best_y_ff     <= '0;
            best_d2_ff    <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      ckind_ff <= ckind_in;
      if (state_ff == ST_IDLE && req_valid && !req_stall) begin
         op_ff   <= req_op;
         last_ff <= req_last_item;
         ax_ff   <= req_a_x[CW-1:0];
         ay_ff   <= req_a_y[CW-1:0];
         bx_ff   <= req_b_x[CW-1:0];
         by_ff   <= req_b_y[CW-1:0];
      end
      case (state_ff)
         ST_IDLE: tol2_ff <= 64'(mul_p);
         ST_CAND: begin
            if (mphase_ff == 2'd0) ex_ff <= 64'(mul_p);
            else ey_ff <= 64'(mul_p);
         end
         ST_PDOT: begin
            if (mphase_ff == 2'd0) begin
               t1_ff <= MW'(mul_p);
               n1_ff <= (mul_p != '0) && (rx[EW-1] != vx[EW-1]);
            end else begin
               t2_ff <= MW'(mul_p);
               n2_ff <= (mul_p != '0) && (ry[EW-1] != vy[EW-1]);
               if (n1_ff == ((mul_p != '0) && (ry[EW-1] != vy[EW-1])))
                  dot_ff <= DW'(t1_ff) + DW'(mul_p);
               else if (t1_ff >= MW'(mul_p))
                  dot_ff <= DW'(t1_ff) - DW'(mul_p);
               else
                  dot_ff <= DW'(mul_p) - DW'(t1_ff);
            end
         end
         ST_PLEN: begin
            if (mphase_ff == 2'd0) len_ff <= DW'(mul_p);
            else len_ff <= len_ff + DW'(mul_p);
         end
         ST_PCHECK: quot_ff <= '0;
         ST_PDIV: begin
            quot_ff <= {quot_ff[QuotBits-2:0], div_ge};
            dot_ff  <= div_ge ? DW'(div_sh - {1'b0, len_ff}) : div_sh[DW-1:0];
         end
         default: ex_ff <= ex_ff;
      endcase
      if (state_ff == ST_OUT) begin
         out_hit_ff  <= best_found_ff;
         out_kind_ff <= best_kind_ff;
         out_x_ff    <= 32'(best_x_ff);
         out_y_ff    <= 32'(best_y_ff);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_hit_valid = out_hit_ff;
   assign rsp_hit_kind  = out_kind_ff;
   assign rsp_hit_x     = out_x_ff;
   assign rsp_hit_y     = out_y_ff;

   `NSPS_ASSERT_IMPL(a_stall_busy, clock, reset,
      (state_ff != ST_IDLE) |-> req_stall, "busy block took an item")
   `NSPS_ASSERT_IMPL(a_out_from_state, clock, reset,
      $rose(out_valid_ff) |-> $past(state_ff) == ST_OUT, "result without end of query")
   `NSPS_ASSERT_IMPL(a_cleared, clock, reset,
      $past(state_ff) == ST_OUT |-> !best_found_ff, "store not cleared after result")
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the nearest snap point selector.
`timescale 1ns / 1ps
module testbench;
   import nsps_pkg::*;

   localparam int          CycleLimit   = 1500000;
   localparam int          DrainCycles  = 80;
   localparam int          RandomPhases = 8;
   localparam int          PhaseItems   = 212;
   localparam bit [2:0]    CSR_UNUSED   = 3'd7;
   localparam int          ResetRows    = 3;
   localparam int          HoldOffStart = 3000;
   localparam int          HoldOffLen   = 500;
   localparam int          QuietStart   = 20000;
   localparam int          QuietLen     = 6000;

   typedef bit [63:0] u64_type;

   typedef struct {
      bit        op;
      bit [2:0]  kind;
      bit [31:0] ax;
      bit [31:0] ay;
      bit [31:0] bx;
      bit [31:0] by;
      bit        last;
   } snap_item_type;

   typedef struct {
      bit        found;
      bit [2:0]  kind;
      bit [31:0] x;
      bit [31:0] y;
   } snap_hit_type;

   typedef struct {
      snap_item_type item;
      bit            typed;
      snap_hit_type  want;
   } snap_row_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic                   req_op         = 1'b0;
   logic [2:0]             req_point_kind = '0;
   logic signed [31:0]     req_a_x        = '0;
   logic signed [31:0]     req_a_y        = '0;
   logic signed [31:0]     req_b_x        = '0;
   logic signed [31:0]     req_b_y        = '0;
   logic                   req_last_item  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic                   rsp_hit_valid;
   logic [2:0]             rsp_hit_kind;
   logic signed [31:0]     rsp_hit_x;
   logic signed [31:0]     rsp_hit_y;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index      = '0;
   logic [31:0]            csr_data       = '0;

   nearest_snap_point_selector dut (.*);

   always #2 clock = ~clock;

   // Predictor copy of the registers and of the kept best.
   longint    cur_x, cur_y, ref_x, ref_y;
   bit [30:0] tol;
   bit        perp_en;
   bit [14:0] prio;
   bit        best_found;
   bit [2:0]  best_kind, best_rank;
   longint    best_px, best_py;
   u64_type   best_d2;

   snap_hit_type hit_queue[$];
   int        errors, cycles, items_sent, results_seen;
   int        sender_idle_pct = 30;

   function automatic u64_type magn(longint v);
      return v < 0 ? u64_type'(-v) : u64_type'(v);
   endfunction

   function automatic void clear_best();
      best_found = 0;
      best_kind  = 0;
      best_rank  = 0;
      best_px    = 0;
      best_py    = 0;
      best_d2    = 0;
   endfunction

   function automatic void apply_register(bit [2:0] idx, bit [31:0] data);
      case (idx)
         CSR_CURSOR_X:    cur_x = longint'(signed'(data));
         CSR_CURSOR_Y:    cur_y = longint'(signed'(data));
         CSR_TOLERANCE:   tol = data[30:0];
         CSR_REFERENCE_X: ref_x = longint'(signed'(data));
         CSR_REFERENCE_Y: ref_y = longint'(signed'(data));
         CSR_PERP_ENABLE: perp_en = data[0];
         CSR_PRIORITIES:  prio = data[14:0];
         default: ;
      endcase
   endfunction

   function automatic void offer_candidate(longint px, longint py, bit [2:0] kind);
      u64_type  dx, dy, ex, ey, d2, tol2;
      bit [2:0] pri;
      dx   = magn(px - cur_x);
      dy   = magn(py - cur_y);
      ex   = dx * dx;
      ey   = dy * dy;
      d2   = ex + ey;
      tol2 = u64_type'(tol) * u64_type'(tol);
      pri  = 3'(prio >> (3 * kind));
      // A wrapped sum means the true distance is beyond 64 bits.
      if (d2 < ex) d2 = '1;
      if (d2 > tol2) return;
      if (!best_found || d2 < best_d2 || (d2 == best_d2 && pri > best_rank)) begin
         best_found = 1;
         best_kind  = kind;
         best_px    = px;
         best_py    = py;
         best_d2    = d2;
         best_rank  = pri;
      end
   endfunction

   function automatic void offer_foot(longint ax, longint ay, longint bx, longint by);
      longint     vx, vy, rx, ry;
      u64_type    p1, p2, sx, sy, q, ox, oy;
      bit         n1, n2, neg;
      bit [127:0] dot, len2;
      vx = bx - ax;
      vy = by - ay;
      rx = ref_x - ax;
      ry = ref_y - ay;
      p1 = magn(rx) * magn(vx);
      p2 = magn(ry) * magn(vy);
      n1 = p1 != 0 && ((rx < 0) != (vx < 0));
      n2 = p2 != 0 && ((ry < 0) != (vy < 0));
      if (vx == 0 && vy == 0) return;
      if (n1 == n2) begin
         dot = {64'd0, p1} + {64'd0, p2};
         neg = n1;
      end else if (p1 >= p2) begin
         dot = p1 - p2;
         neg = n1;
      end else begin
         dot = p2 - p1;
         neg = n2;
      end
      sx   = magn(vx) * magn(vx);
      sy   = magn(vy) * magn(vy);
      len2 = {64'd0, sx} + {64'd0, sy};
      if (neg || dot == 0) begin
         offer_candidate(ax, ay, KIND_PERP);
         return;
      end
      if (dot >= len2) begin
         offer_candidate(bx, by, KIND_PERP);
         return;
      end
      q = 0;
      for (int i = 0; i < 32; i++) begin
         dot = dot << 1;
         q   = q << 1;
         if (dot >= len2) begin
            dot  = dot - len2;
            q[0] = 1'b1;
         end
      end
      ox = (q * magn(vx)) >> 32;
      oy = (q * magn(vy)) >> 32;
      offer_candidate(vx < 0 ? ax - longint'(ox) : ax + longint'(ox),
                      vy < 0 ? ay - longint'(oy) : ay + longint'(oy), KIND_PERP);
   endfunction

   function automatic void predict_snap(snap_item_type it, output bit has_hit,
                                        output snap_hit_type hit);
      longint ax, ay, bx, by;
      ax = longint'(signed'(it.ax));
      ay = longint'(signed'(it.ay));
      bx = longint'(signed'(it.bx));
      by = longint'(signed'(it.by));
      if (!it.op) begin
         if (it.kind <= KIND_SURVEY) offer_candidate(ax, ay, it.kind);
      end else begin
         offer_candidate(ax, ay, KIND_ENDPOINT);
         offer_candidate(bx, by, KIND_ENDPOINT);
         // Arithmetic shift rounds the midpoint toward minus infinity.
         offer_candidate((ax + bx) >>> 1, (ay + by) >>> 1, KIND_MIDPOINT);
         if (perp_en) offer_foot(ax, ay, bx, by);
      end
      has_hit   = it.last;
      hit.found = best_found;
      hit.kind  = best_kind;
      hit.x     = 32'(best_px);
      hit.y     = 32'(best_py);
      if (it.last) clear_best();
   endfunction

   task automatic report_mismatch(string what);
      errors++;
      $display("MISMATCH at cycle %0d: %s", cycles, what);
   endtask

   task automatic write_register(bit [2:0] idx, bit [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(snap_item_type it, bit typed, snap_hit_type want);
      bit           has_hit;
      snap_hit_type hit;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= it.op;
      req_point_kind <= it.kind;
      req_a_x        <= it.ax;
      req_a_y        <= it.ay;
      req_b_x        <= it.bx;
      req_b_y        <= it.by;
      req_last_item  <= it.last;
      do @(posedge clock); while (req_stall);
      predict_snap(it, has_hit, hit);
      if (has_hit) hit_queue.push_back(typed ? want : hit);
      items_sent++;
   endtask

   // Lowers valid straight after the last transfer and lets the block go quiet.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (hit_queue.size() == 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic bit [31:0] near_coord(longint centre, longint span);
      longint offset;
      if ($urandom_range(0, 9) < 2) return $urandom;
      offset = longint'($urandom_range(0, 32'(2 * span))) - span;
      return 32'(centre + offset);
   endfunction

   snap_row_type directed_rows[] = '{
      // Reset settings: zero tolerance, all priorities zero, no feet.
      '{'{1'b0, KIND_SURVEY, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, KIND_SURVEY, 0, 0}},
      '{'{1'b0, KIND_ENDPOINT, 1, 0, 0, 0, 1'b1}, 1'b1, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, -1, 0, 1, 0, 1'b1}, 1'b1, '{1'b1, KIND_MIDPOINT, 0, 0}},
      // Tolerance 4096, reference at (1000, 5000), feet enabled.
      '{'{1'b0, KIND_ENDPOINT, 100, 100, 0, 0, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, KIND_CENTER, 10, 0, 0, 0, 1'b0}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, KIND_SURVEY, 0, 10, 0, 0, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, KIND_SURVEY, 0, 10, 0, 0, 1'b0}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, KIND_CENTER, 10, 0, 0, 0, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, KIND_MIDPOINT, 30, 30, 0, 0, 1'b0}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, KIND_PERP, -30, 30, 0, 0, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, -5, -5, 2, 2, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, 50, 50, 50, 50, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, 2000, 0, 3000, 0, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, -3000, 0, -2000, 0, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, 0, -2000, 2000, 2000, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, -4000, 3000, 4000, -3000, 1'b1}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, 3'd6, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, 3'd5, 0, 0, 0, 0, 1'b0}, 1'b0, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, 3'd7, 1, 1, -1, -1, 1'b1}, 1'b1, '{1'b0, 3'd0, 0, 0}},
      '{'{1'b0, KIND_ENDPOINT, 32'h7fffffff, 32'h80000000, -1, -1, 1'b1}, 1'b1,
        '{1'b0, 3'd0, 0, 0}},
      '{'{1'b1, 3'd0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1},
        1'b0, '{1'b0, 3'd0, 0, 0}}
   };

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off and one stretch without stalls.
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (cycles >= HoldOffStart && cycles < HoldOffStart + HoldOffLen)
         rsp_stall <= 1'b1;
      else if (cycles >= QuietStart && cycles < QuietStart + QuietLen)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= $urandom_range(0, 99) < 30;
   end

   always @(posedge clock) begin : check_results
      snap_hit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (hit_queue.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = hit_queue.pop_front();
            if (rsp_hit_valid !== want.found)
               report_mismatch($sformatf("hit_valid %b, expected %b", rsp_hit_valid,
                                         want.found));
            if (rsp_hit_kind !== want.kind)
               report_mismatch($sformatf("hit_kind %0d, expected %0d", rsp_hit_kind,
                                         want.kind));
            if (rsp_hit_x !== want.x)
               report_mismatch($sformatf("hit_x %h, expected %h", rsp_hit_x, want.x));
            if (rsp_hit_y !== want.y)
               report_mismatch($sformatf("hit_y %h, expected %h", rsp_hit_y, want.y));
         end
      end
   end

   initial begin : stimulus
      snap_item_type it;
      snap_hit_type  none;
      longint        span;
      bit [31:0]     cx, cy;
      none = '{1'b0, 3'd0, 0, 0};
      cur_x = 0; cur_y = 0; ref_x = 0; ref_y = 0;
      tol = 0; perp_en = 0; prio = 0;
      clear_best();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (i == ResetRows) begin
            drain_block();
            write_register(CSR_TOLERANCE, 4096);
            write_register(CSR_REFERENCE_X, 1000);
            write_register(CSR_REFERENCE_Y, 5000);
            write_register(CSR_PERP_ENABLE, 1);
            write_register(CSR_PRIORITIES, 1 | (2 << 3) | (3 << 6) | (4 << 9) | (5 << 12));
         end
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         drain_block();
         cx = $urandom;
         cy = $urandom;
         if (phase == 1) begin cx = 32'h7fffffff; cy = 32'h80000000; end
         if (phase == 2) begin cx = 32'h80000000; cy = 32'h7fffffff; end
         write_register(CSR_CURSOR_X, cx);
         write_register(CSR_CURSOR_Y, cy);
         case (phase)
            0:       write_register(CSR_TOLERANCE, 0);
            3:       write_register(CSR_TOLERANCE, 32'h7fffffff);
            4:       write_register(CSR_TOLERANCE, 32'hffffffff);
            default: write_register(CSR_TOLERANCE,
                        {1'($urandom_range(0, 1)),
                         31'($urandom_range(0, 1 << $urandom_range(4, 28)))});
         endcase
         write_register(CSR_REFERENCE_X, near_coord(cur_x, 1 << 16));
         write_register(CSR_REFERENCE_Y, near_coord(cur_y, 1 << 16));
         write_register(CSR_PERP_ENABLE, phase == 5 ? 32'hfffffffe : $urandom);
         write_register(CSR_PRIORITIES, $urandom);
         write_register(CSR_UNUSED, $urandom);
         sender_idle_pct = (phase == 6) ? 0 : 30;
         span = longint'(tol) + longint'(tol >> 1) + 4;
         if (span > (1 << 30)) span = 1 << 30;
         for (int n = 0; n < PhaseItems; n++) begin
            it.op   = 1'($urandom_range(0, 1));
            it.kind = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                 : 3'($urandom_range(5, 7));
            it.ax   = near_coord(cur_x, span);
            it.ay   = near_coord(cur_y, span);
            it.bx   = near_coord(cur_x, span);
            it.by   = near_coord(cur_y, span);
            if ($urandom_range(0, 19) == 0) begin
               it.bx = it.ax;
               it.by = it.ay;
            end
            it.last = ($urandom_range(0, 3) == 0) || (n == PhaseItems - 1);
            send_item(it, 1'b0, none);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (hit_queue.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      $display("Covered %0d candidate items and %0d query results over %0d settings.",
               items_sent, results_seen, RandomPhases + 2);
      $display("Included zero and full tolerance, extreme cursors and a long result hold-off.");
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nsps_pkg.sv
hdl/nearest_snap_point_selector.sv
bench/testbench.sv
